/* hdl/sobel_pkg.sv */
package sobel_pkg;

   localparam int PIXEL_W     = 16;
   localparam int GRAD_W      = 16;
   localparam int MAG_W       = 17;
   localparam int SUM_W       = 19;
   localparam int RSP_DATA_W  = 56;
   localparam int WIDTH_REG_W = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W  = 13;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_addr_type;

   typedef logic signed [PIXEL_W-1:0] pixel_type;
   typedef logic signed [GRAD_W-1:0]  grad_type;

endpackage

/* hdl/sobel_gradient_3x3_unit.sv */
// channel  | direction | handshake              | payload
// req      | in        | req_tvalid/req_tready  | tdata[15:0] pixel
// rsp      | out       | rsp_tvalid/rsp_tready  | tdata grad_x, grad_y, magnitude; tlast frame_end
// csr      | in        | csr_we                 | csr_addr register, csr_wdata value
//
// one pixel per cycle sustained while rsp_tready is high; a result leaves through the
// line store read register, window, gradient register and output register in turn
// the first of these is the registered read of the two line store memories
// every stage has its own valid, so a stalled result does not stop input until
// all stages are full
// synchronous active-high reset clears control state and restores 640 x 480;
// line stores are not cleared
module sobel_gradient_3x3_unit #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [sobel_pkg::PIXEL_W-1:0]           req_tdata,   // [15:0] pixel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [15:0] grad_x, [31:16] grad_y, [48:32] magnitude, [55:49] zero
   output logic [sobel_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast,
   input  logic                                   csr_we,
   input  sobel_pkg::csr_addr_type                 csr_addr,
   input  logic [sobel_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import sobel_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   // configuration
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [31:0]             w_wide, h_wide, w_eff, h_eff;
   logic [CW-1:0]           w_last;
   logic [RW-1:0]           h_last;

   // position counters
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // line stores
   pixel_type above_mem [MAX_WIDTH];
   pixel_type two_mem   [MAX_WIDTH];
   pixel_type above_rd_ff, two_rd_ff;

   // stage 1: memory read data
   logic          s1_vld_ff, s1_prod_ff, s1_last_ff;
   logic [CW-1:0] s1_col_ff;
   pixel_type     s1_px_ff;

   // stage 2: window holds the neighborhood
   pixel_type win_ff [9];
   logic      s2_vld_ff, s2_last_ff;

   // stage 3: gradients
   grad_type gx_ff, gy_ff;
   logic     s3_vld_ff, s3_last_ff;

   // output register
   grad_type           rsp_gx_ff, rsp_gy_ff;
   logic [MAG_W-1:0]   rsp_mag_ff;
   logic               rsp_vld_ff, rsp_last_ff;

   logic req_fire, s1_adv, s2_adv, s3_adv;
   logic s2_ready, s3_ready, out_ready;
   logic produce, frame_last;

   logic signed [SUM_W-1:0] we [9];
   logic signed [SUM_W-1:0] sum_x, sum_y, shx, shy;
   logic signed [MAG_W-1:0] gx17, gy17;
   logic [MAG_W-1:0]        ax, ay;

   // dimension clamp to [3, max]
   always_comb begin
      w_wide = 32'(width_ff);
      h_wide = 32'(height_ff);
      if (w_wide < 32'd3) w_eff = 32'd3;
      else if (w_wide > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
      else w_eff = w_wide;
      if (h_wide < 32'd3) h_eff = 32'd3;
      else if (h_wide > 32'(MAX_HEIGHT)) h_eff = 32'(MAX_HEIGHT);
      else h_eff = h_wide;
      w_last = CW'(w_eff - 32'd1);
      h_last = RW'(h_eff - 32'd1);
   end

   assign out_ready  = !rsp_vld_ff || rsp_tready;
   assign s3_ready   = !s3_vld_ff || out_ready;
   assign s2_ready   = !s2_vld_ff || s3_ready;
   assign req_tready = !s1_vld_ff || s2_ready;
   assign req_fire   = req_tvalid && req_tready;
   assign s1_adv     = s1_vld_ff && s2_ready;
   assign s2_adv     = s2_vld_ff && s3_ready;
   assign s3_adv     = s3_vld_ff && out_ready;

   assign produce    = (row_ff >= RW'(2)) && (col_ff >= CW'(2));
   assign frame_last = (row_ff == h_last) && (col_ff == w_last);

   always_comb begin
      if (col_ff >= w_last) begin
         col_in = '0;
         row_in = (row_ff >= h_last) ? '0 : row_ff + RW'(1);
      end else begin
         col_in = col_ff + CW'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_fire) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line_above: read old, write new pixel at the same column
   always_ff @(posedge clock) begin
      if (req_fire) begin
         above_rd_ff     <= above_mem[col_ff];
         above_mem[col_ff] <= req_tdata;
      end
   end

   // line_two_above takes the old line_above entry from its read register when stage 1 advances
   always_ff @(posedge clock) begin
      if (req_fire) begin
         two_rd_ff <= two_mem[col_ff];
      end
      if (s1_adv) begin
         two_mem[s1_col_ff] <= above_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_tready) begin
         s1_vld_ff <= req_fire;
      end
      if (req_fire) begin
         s1_col_ff  <= col_ff;
         s1_px_ff   <= req_tdata;
         s1_prod_ff <= produce;
         s1_last_ff <= frame_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else if (s1_adv) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k*3+0] <= win_ff[k*3+1];
            win_ff[k*3+1] <= win_ff[k*3+2];
         end
         win_ff[2] <= two_rd_ff;
         win_ff[5] <= above_rd_ff;
         win_ff[8] <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_vld_ff <= s1_adv && s1_prod_ff;
      end
      if (s1_adv) begin
         s2_last_ff <= s1_last_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 9; i++) we[i] = SUM_W'(win_ff[i]);
      sum_x = (we[2] - we[0]) + ((we[5] - we[3]) <<< 1) + (we[8] - we[6]);
      sum_y = (we[6] - we[0]) + ((we[7] - we[1]) <<< 1) + (we[8] - we[2]);
      shx   = sum_x >>> 3;
      shy   = sum_y >>> 3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_vld_ff <= s2_adv;
      end
      if (s2_adv) begin
         gx_ff      <= shx[GRAD_W-1:0];
         gy_ff      <= shy[GRAD_W-1:0];
         s3_last_ff <= s2_last_ff;
      end
   end

   always_comb begin
      gx17 = MAG_W'(gx_ff);
      gy17 = MAG_W'(gy_ff);
      ax   = (gx17 < 0) ? MAG_W'(-gx17) : MAG_W'(gx17);
      ay   = (gy17 < 0) ? MAG_W'(-gy17) : MAG_W'(gy17);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_vld_ff <= s3_adv;
      end
      if (s3_adv) begin
         rsp_gx_ff   <= gx_ff;
         rsp_gy_ff   <= gy_ff;
         rsp_mag_ff  <= ax + ay;
         rsp_last_ff <= s3_last_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 2*GRAD_W - MAG_W)'(0), rsp_mag_ff, rsp_gy_ff, rsp_gx_ff};

   // input stalls only when every stage is occupied
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_vld_ff && s2_vld_ff && s3_vld_ff && rsp_vld_ff))
      else $error("input stalled with a free stage");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= w_last) && (row_ff <= h_last))
      else $error("position counter beyond frame");

   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (col_ff == '0) && (row_ff == '0))
      else $error("register write did not restart frame");

   // negate at 17 bits so the most negative gradient stays positive
   a_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_mag_ff >= (rsp_gx_ff[GRAD_W-1] ? -MAG_W'(rsp_gx_ff)
                                                          : MAG_W'(rsp_gx_ff))))
      else $error("magnitude below horizontal gradient");

endmodule
